// File: rtl/cft_pkg.sv
`default_nettype none

package cft_pkg;

   // Widest number of fields a record may carry before the index saturates.
   localparam int MAX_FIELDS = 32;

   localparam int FIELD_W = 5;
   localparam int BYTE_W  = 8;

   // The index stops at the smaller of MAX_FIELDS-1 and the largest 5-bit value.
   localparam int FIELD_CAP_INT = ((MAX_FIELDS - 1) < ((1 << FIELD_W) - 1)) ?
                                  (MAX_FIELDS - 1) : ((1 << FIELD_W) - 1);
   localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_CAP_INT[FIELD_W-1:0];

   localparam logic [BYTE_W-1:0] LINE_FEED = 8'd10;

   // Register reset values.
   localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
   localparam logic              HEADER_RESET    = 1'b1;

   // Register indexes on the write port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER    = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      MODE_PLAIN      = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_QUOTE_SEEN = 2'd2,
      MODE_DROPPING   = 2'd3
   } mode_type;

   // A byte together with its classification against the current config.
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              is_sep;
      logic              is_nl;
      logic              is_quote;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/cft_front.sv
`default_nettype none

module cft_front (
   input  wire logic [cft_pkg::BYTE_W-1:0] text_byte,
   input  wire logic [cft_pkg::BYTE_W-1:0] separator_char,
   input  wire logic [cft_pkg::BYTE_W-1:0] quote_char,
   output cft_pkg::item_type               item
);
   import cft_pkg::*;

   // Classify the byte; the back end resolves priority between the flags.
   always_comb begin
      item.text_byte = text_byte;
      item.is_sep    = (text_byte == separator_char);
      item.is_nl     = (text_byte == LINE_FEED);
      item.is_quote  = (text_byte == quote_char);
   end

endmodule

`default_nettype wire

// File: rtl/cft_queue.sv
`default_nettype none

module cft_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  wire cft_pkg::item_type             push_item,
   output logic                               push_stall,
   output logic                               pop_valid,
   output cft_pkg::item_type                  pop_item,
   input  wire logic                          pop_take,
   output logic [cft_pkg::QUEUE_CNT_W-1:0]    count
);
   import cft_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     push;
   logic                     pop;

   localparam logic [QUEUE_CNT_W-1:0] FULL = QUEUE_DEPTH[QUEUE_CNT_W-1:0];
   localparam logic [QUEUE_CNT_W-1:0] ONE  = {{(QUEUE_CNT_W-1){1'b0}}, 1'b1};
   localparam logic [QUEUE_PTR_W-1:0] STEP = {{(QUEUE_PTR_W-1){1'b0}}, 1'b1};

   assign push_stall = (count_ff == FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   assign push = push_valid && !push_stall;
   assign pop  = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + STEP : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + STEP : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + ONE;
      end else if (pop && !push) begin
         count_in = count_ff - ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cft_back.sv
`default_nettype none

module cft_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   input  wire cft_pkg::item_type           pop_item,
   output logic                             pop_take,
   input  wire logic                        header_enable,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_byte_valid,
   output logic [cft_pkg::BYTE_W-1:0]       rsp_data_byte,
   output logic                             rsp_field_end,
   output logic                             rsp_record_end,
   output logic                             rsp_in_header,
   output logic [cft_pkg::FIELD_W-1:0]      rsp_field_number
);
   import cft_pkg::*;

   mode_type             mode_ff;
   mode_type             mode_in;
   logic                 header_done_ff;
   logic                 header_done_in;
   logic [FIELD_W-1:0]   field_ff;
   logic [FIELD_W-1:0]   field_in;

   logic                 emit;
   logic                 emit_byte;
   logic                 emit_field_end;
   logic                 emit_record_end;
   logic                 step;

   logic                 valid_ff;
   logic                 valid_in;
   logic                 byte_valid_ff;
   logic [BYTE_W-1:0]    data_ff;
   logic                 field_end_ff;
   logic                 record_end_ff;
   logic                 in_header_ff;
   logic [FIELD_W-1:0]   number_ff;

   // The output register frees up when it is empty or being taken this cycle.
   assign pop_take = !valid_ff || !rsp_stall;
   assign step     = pop_valid && pop_take;

   // Next quote mode.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_PLAIN: begin
            if (!pop_item.is_sep && !pop_item.is_nl && pop_item.is_quote) begin
               mode_in = MODE_QUOTED;
            end
         end
         MODE_QUOTED: begin
            if (pop_item.is_quote) begin
               mode_in = MODE_QUOTE_SEEN;
            end
         end
         MODE_QUOTE_SEEN: begin
            if (pop_item.is_quote) begin
               mode_in = MODE_QUOTED;
            end else if (pop_item.is_sep || pop_item.is_nl) begin
               mode_in = MODE_PLAIN;
            end else begin
               mode_in = MODE_DROPPING;
            end
         end
         MODE_DROPPING: begin
            if (pop_item.is_sep || pop_item.is_nl) begin
               mode_in = MODE_PLAIN;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
         end
      endcase
   end

   // Result produced by the byte in the current mode.
   always_comb begin
      emit_byte       = 1'b0;
      emit_field_end  = 1'b0;
      emit_record_end = 1'b0;
      case (mode_ff)
         MODE_PLAIN: begin
            if (pop_item.is_sep) begin
               emit_field_end = 1'b1;
            end else if (pop_item.is_nl) begin
               emit_field_end  = 1'b1;
               emit_record_end = 1'b1;
            end else if (!pop_item.is_quote) begin
               emit_byte = 1'b1;
            end
         end
         MODE_QUOTED: begin
            emit_byte = !pop_item.is_quote;
         end
         MODE_QUOTE_SEEN: begin
            if (pop_item.is_quote) begin
               emit_byte = 1'b1;
            end else if (pop_item.is_sep) begin
               emit_field_end = 1'b1;
            end else if (pop_item.is_nl) begin
               emit_field_end  = 1'b1;
               emit_record_end = 1'b1;
            end
         end
         MODE_DROPPING: begin
            if (pop_item.is_sep) begin
               emit_field_end = 1'b1;
            end else if (pop_item.is_nl) begin
               emit_field_end  = 1'b1;
               emit_record_end = 1'b1;
            end
         end
         default: begin
            emit_byte = 1'b0;
         end
      endcase
      emit = emit_byte || emit_field_end;
   end

   // Field index and header tracking.
   always_comb begin
      field_in       = field_ff;
      header_done_in = header_done_ff;
      if (emit_record_end) begin
         field_in       = '0;
         header_done_in = 1'b1;
      end else if (emit_field_end && (field_ff < FIELD_CAP)) begin
         field_in = field_ff + {{(FIELD_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (step) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PLAIN;
         header_done_ff <= 1'b0;
         field_ff       <= '0;
         valid_ff       <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            mode_ff        <= mode_in;
            header_done_ff <= header_done_in;
            field_ff       <= field_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         byte_valid_ff <= emit_byte;
         data_ff       <= emit_byte ? pop_item.text_byte : '0;
         field_end_ff  <= emit_field_end;
         record_end_ff <= emit_record_end;
         in_header_ff  <= header_enable && !header_done_ff;
         number_ff     <= field_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_field_end    = field_end_ff;
   assign rsp_record_end   = record_end_ff;
   assign rsp_in_header    = in_header_ff;
   assign rsp_field_number = number_ff;

endmodule

`default_nettype wire

// File: rtl/csv_field_tokenizer.sv
// CSV field tokenizer: splits a stream of CSV text into field bytes and marks.
//
// The req channel takes one byte of text per item. The rsp channel gives at
// most one item per byte: either an unescaped content byte, or a field end
// (with record end on a line feed), each tagged with the field index within
// the record and whether the record is the header. Opening quotes, quote
// escapes and bytes after a closing quote produce no rsp item.
// The csr port writes the separator, the quote character and the header
// enable; the user must write it only while no item is in flight, since
// the block itself does not enforce this. The req channel takes one byte
// per cycle while rsp_stall is low; a two-entry queue sits between the
// classification and the back end's state update, and the result sits
// in an output register.
// When rsp_stall is high the output register holds, the queue fills, and
// once it holds two items req_stall rises until the receiver takes a result.
// Reset (synchronous, active high) empties the queue and the output register,
// restores the default registers and starts a fresh stream whose first
// record is the header.

`default_nettype none

module csv_field_tokenizer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_text_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_byte_valid,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_field_end,
   output logic              rsp_record_end,
   output logic              rsp_in_header,
   output logic [4:0]        rsp_field_number,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_write_data
);
   import cft_pkg::*;

   logic [BYTE_W-1:0]       separator_ff;
   logic [BYTE_W-1:0]       quote_ff;
   logic                    header_enable_ff;

   item_type                front_item;
   item_type                queue_item;
   logic                    queue_valid;
   logic                    queue_take;
   logic [QUEUE_CNT_W-1:0]  queue_count;

   // Configuration registers. Writes to an unused index are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff     <= SEPARATOR_RESET;
         quote_ff         <= QUOTE_RESET;
         header_enable_ff <= HEADER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEPARATOR: separator_ff     <= csr_write_data;
            CSR_QUOTE:     quote_ff         <= csr_write_data;
            CSR_HEADER:    header_enable_ff <= csr_write_data[0];
            default:       separator_ff     <= separator_ff;
         endcase
      end
   end

   // Front end: compare the incoming byte against the special characters.
   cft_front u_front (
      .text_byte      (req_text_byte),
      .separator_char (separator_ff),
      .quote_char     (quote_ff),
      .item           (front_item)
   );

   // Short queue so the front end keeps accepting while the back end stalls.
   cft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_item  (front_item),
      .push_stall (req_stall),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_take   (queue_take),
      .count      (queue_count)
   );

   // Back end: quote state machine, field counter and output register.
   cft_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (queue_valid),
      .pop_item         (queue_item),
      .pop_take         (queue_take),
      .header_enable    (header_enable_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_field_end    (rsp_field_end),
      .rsp_record_end   (rsp_record_end),
      .rsp_in_header    (rsp_in_header),
      .rsp_field_number (rsp_field_number)
   );

   // A record end is always a field end as well.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_end |-> rsp_field_end)
      else $error("record end without field end");

   // A result is either a content byte or an end mark, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_field_end && !rsp_record_end)
      else $error("content byte combined with an end mark");

   // The queue never holds more than its depth, and stalls the input when full.
   assert property (@(posedge clock) disable iff (reset)
      (queue_count <= QUEUE_DEPTH[QUEUE_CNT_W-1:0]) &&
      (req_stall == (queue_count == QUEUE_DEPTH[QUEUE_CNT_W-1:0])))
      else $error("queue occupancy out of range");

   // The field index never passes its saturation point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_field_number <= FIELD_CAP)
      else $error("field index beyond its cap");

endmodule

`default_nettype wire

// File: dv/csv_field_tokenizer_tb.sv
`default_nettype none

module csv_field_tokenizer_tb;
   import cft_pkg::*;

   // The write port has four index codes but only three registers; this one
   // must be ignored by the block.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Cycles to let pass once every expected result has arrived, since a trailing
   // silent byte gives no sign of being done.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 50000;

   // One result item as the tokenizer should emit it.
   typedef struct {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       field_end;
      logic       record_end;
      logic       in_header;
      logic [4:0] field_number;
   } token_type;

   logic         clock;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   logic [7:0]   req_text_byte    = 8'h00;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   logic         rsp_byte_valid;
   logic [7:0]   rsp_data_byte;
   logic         rsp_field_end;
   logic         rsp_record_end;
   logic         rsp_in_header;
   logic [4:0]   rsp_field_number;
   logic         csr_write_enable = 1'b0;
   logic [1:0]   csr_index        = CSR_SEPARATOR;
   logic [7:0]   csr_write_data   = 8'h00;

   csv_field_tokenizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_field_end    (rsp_field_end),
      .rsp_record_end   (rsp_record_end),
      .rsp_in_header    (rsp_in_header),
      .rsp_field_number (rsp_field_number),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is bounded by a fixed time far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tokenizer state as the testbench tracks it. The configuration copy is
   // changed only together with a register write, while the block is idle.
   // ------------------------------------------------------------------------
   logic [7:0] cfg_separator = SEPARATOR_RESET;
   logic [7:0] cfg_quote     = QUOTE_RESET;
   logic       cfg_header    = HEADER_RESET;
   mode_type   tok_mode      = MODE_PLAIN;
   logic       header_seen   = 1'b0;
   logic [4:0] field_index   = '0;

   token_type  expected_tokens[$];
   logic [7:0] pending_bytes[$];
   int         bytes_issued   = 0;
   int         bytes_accepted = 0;
   int         tokens_checked = 0;
   int         error_count    = 0;

   // Knobs that the stimulus sequence turns per phase.
   logic       allow_gaps   = 1'b1;
   logic       hold_trigger = 1'b0;
   int         hold_left    = 0;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count = error_count + 1;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         flag_error($sformatf("result %0d: %s is %0h, should be %0h",
                              tokens_checked, name, got, want));
   endtask

   // The header flag and the field index are those in force before this byte
   // moves the tokenizer on.
   function automatic void push_token(input logic valid, input logic [7:0] data,
                                      input logic fend, input logic rend);
      token_type t;
      t.byte_valid   = valid;
      t.data_byte    = valid ? data : 8'h00;
      t.field_end    = fend;
      t.record_end   = rend;
      t.in_header    = cfg_header & ~header_seen;
      t.field_number = field_index;
      expected_tokens.push_back(t);
   endfunction

   // Works out what one accepted text byte yields and moves the state on.
   // Where codes coincide the quote test wins within quotes, else separator, then line feed, then quote.
   function automatic void tokenize_byte(input logic [7:0] b);
      logic is_sep;
      logic is_nl;
      logic is_quote;
      is_sep   = (b == cfg_separator);
      is_nl    = (b == LINE_FEED);
      is_quote = (b == cfg_quote);
      if (tok_mode == MODE_QUOTED) begin
         if (is_quote)
            tok_mode = MODE_QUOTE_SEEN;
         else
            push_token(1'b1, b, 1'b0, 1'b0);
      end else if (tok_mode == MODE_QUOTE_SEEN && is_quote) begin
         // A doubled quote stands for one quote byte of content.
         tok_mode = MODE_QUOTED;
         push_token(1'b1, b, 1'b0, 1'b0);
      end else if (tok_mode == MODE_QUOTE_SEEN || tok_mode == MODE_DROPPING) begin
         // The quoted part is closed; only a separator or line feed counts now.
         if (is_sep) begin
            tok_mode = MODE_PLAIN;
            push_token(1'b0, 8'h00, 1'b1, 1'b0);
            if (field_index < FIELD_CAP)
               field_index = field_index + 5'd1;
         end else if (is_nl) begin
            tok_mode = MODE_PLAIN;
            push_token(1'b0, 8'h00, 1'b1, 1'b1);
            field_index = '0;
            header_seen = 1'b1;
         end else begin
            tok_mode = MODE_DROPPING;
         end
      end else begin
         if (is_sep) begin
            push_token(1'b0, 8'h00, 1'b1, 1'b0);
            if (field_index < FIELD_CAP)
               field_index = field_index + 5'd1;
         end else if (is_nl) begin
            push_token(1'b0, 8'h00, 1'b1, 1'b1);
            field_index = '0;
            header_seen = 1'b1;
         end else if (is_quote) begin
            tok_mode = MODE_QUOTED;
         end else begin
            push_token(1'b1, b, 1'b0, 1'b0);
         end
      end
   endfunction

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!allow_gaps || r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Sender. An item stays on the port, unchanged, until it is taken; only
   // then does the driver decide between the next byte and an idle gap.
   // ------------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            tokenize_byte(req_text_byte);
            bytes_accepted = bytes_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid <= 1'b1;
               req_text_byte <= pending_bytes.pop_front();
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so that the sender keeps offering
   // items while results back up and the block has to stall its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_trigger) begin
         hold_trigger = 1'b0;
         hold_left = 200;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. Each result taken is checked field by field against the oldest
   // expectation; the stall for the next cycle is chosen afterwards.
   // ------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               flag_error($sformatf("result with nothing expected: valid %0b data %02h end %0b%0b",
                                    rsp_byte_valid, rsp_data_byte, rsp_field_end,
                                    rsp_record_end));
            end else begin
               want = expected_tokens.pop_front();
               compare_field("byte_valid", int'(rsp_byte_valid), int'(want.byte_valid));
               compare_field("data_byte", int'(rsp_data_byte), int'(want.data_byte));
               compare_field("field_end", int'(rsp_field_end), int'(want.field_end));
               compare_field("record_end", int'(rsp_record_end), int'(want.record_end));
               compare_field("in_header", int'(rsp_in_header), int'(want.in_header));
               compare_field("field_number", int'(rsp_field_number),
                             int'(want.field_number));
            end
            tokens_checked = tokens_checked + 1;
         end
         if (stall_left > 0)
            stall_left = stall_left - 1;
         else if ($urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic void queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_issued = bytes_issued + 1;
   endfunction

   // A random byte that is neither separator, line feed nor quote under the
   // configuration of the phase being built.
   function automatic logic [7:0] ordinary_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == cfg_separator || b == LINE_FEED || b == cfg_quote);
      return b;
   endfunction

   // Builds records of random content. Most fields are well formed: plain,
   // quoted with embedded separators, line feeds and doubled quotes, quoted
   // after some plain bytes, or closed with trailing bytes to be dropped.
   // The rest is raw noise. Now and then a record runs past the field cap.
   task automatic queue_records(input int count);
      int goal;
      int n_fields;
      int kind;
      int len;
      int r;
      goal = bytes_issued + count;
      while (bytes_issued < goal) begin
         if ($urandom_range(0, 19) == 0)
            n_fields = $urandom_range(30, 36);
         else
            n_fields = $urandom_range(1, 5);
         for (int f = 0; f < n_fields; f++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4 || kind == 7) begin
               len = $urandom_range(0, 5);
               for (int i = 0; i < len; i++)
                  queue_byte(ordinary_byte());
            end
            if (kind >= 4 && kind < 8) begin
               queue_byte(cfg_quote);
               len = $urandom_range(0, 6);
               for (int i = 0; i < len; i++) begin
                  r = $urandom_range(0, 9);
                  if (r == 0) begin
                     queue_byte(cfg_separator);
                  end else if (r == 1) begin
                     queue_byte(LINE_FEED);
                  end else if (r == 2) begin
                     queue_byte(cfg_quote);
                     queue_byte(cfg_quote);
                  end else begin
                     queue_byte(ordinary_byte());
                  end
               end
               queue_byte(cfg_quote);
               if (kind == 6) begin
                  len = $urandom_range(1, 3);
                  for (int i = 0; i < len; i++)
                     queue_byte(($urandom_range(0, 3) == 0) ? cfg_quote : ordinary_byte());
               end
            end
            if (kind >= 8) begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++)
                  queue_byte(8'($urandom_range(0, 255)));
            end
            queue_byte((f == n_fields - 1) ? LINE_FEED : cfg_separator);
         end
      end
   endtask

   // Waits until every byte is taken and every expected result has come back,
   // then lets the block settle so a trailing silent byte is finished too.
   task automatic wait_drained();
      int spin;
      spin = 0;
      while ((bytes_accepted != bytes_issued || expected_tokens.size() != 0)
             && spin < DRAIN_LIMIT) begin
         @(negedge clock);
         spin = spin + 1;
      end
      if (expected_tokens.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived", expected_tokens.size()));
         expected_tokens.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write; the tracked configuration follows it. Unknown
   // indexes leave everything as it was.
   task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_SEPARATOR: cfg_separator = data;
         CSR_QUOTE:     cfg_quote = data;
         CSR_HEADER:    cfg_header = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] sep, input logic [7:0] quote,
                             input logic hdr);
      wait_drained();
      write_register(CSR_SEPARATOR, sep);
      write_register(CSR_QUOTE, quote);
      write_register(CSR_HEADER, {7'b0, hdr});
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   logic [7:0] directed_text [0:24];

   initial begin
      // Default registers. The first line is the header: a plain field with a
      // zero byte, a quoted field holding 0xFF, a doubled quote, a separator
      // and a line feed, then a field with a quote in the middle whose closing
      // quote is followed by bytes to be dropped (a quote and a carriage
      // return among them). The second line starts with a carriage return as
      // data and ends on an empty quoted field closed by the line feed.
      directed_text = '{8'h68, 8'h00, 8'h2C, 8'h22, 8'hFF, 8'h22, 8'h22, 8'h2C,
                        8'h0A, 8'h22, 8'h2C, 8'h78, 8'h22, 8'h79, 8'h22, 8'h7A,
                        8'h22, 8'h0D, 8'h0A, 8'h0D, 8'h2C, 8'h22, 8'h22, 8'h0A,
                        8'hAA};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++)
         queue_byte(directed_text[i]);
      wait_drained();

      // Random records under the defaults, with one long receiver hold-off
      // while plenty of input is still waiting.
      queue_records(300);
      hold_trigger = 1'b1;

      // Extreme codes, header flag off, and a write to the unused index.
      set_config(8'h00, 8'hFF, 1'b0);
      write_register(CSR_UNUSED, 8'h5A);
      queue_records(200);

      // Separator and quote on the same code; the separator must win. This
      // phase runs with no idle cycles on either side.
      set_config(8'h7C, 8'h7C, 1'b1);
      allow_gaps = 1'b0;
      queue_records(200);

      // Separator equal to line feed: outside quotes a line feed only ends a field.
      set_config(LINE_FEED, 8'h00, 1'b1);
      allow_gaps = 1'b1;
      queue_records(200);

      // Quote equal to line feed: outside quotes the line feed ends the record.
      set_config(8'hFF, LINE_FEED, 1'b0);
      queue_records(250);

      // Back to the defaults. The header was done long ago, so turning the
      // flag on again must not mark any record as header. The stream then
      // stops in the middle of a line that is never closed.
      set_config(SEPARATOR_RESET, QUOTE_RESET, HEADER_RESET);
      queue_records(250);
      queue_byte(8'h61);
      queue_byte(QUOTE_RESET);
      queue_byte(8'h62);

      wait_drained();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
